// ===== sv/tbm_pkg.sv =====
// ============================================================================
// tbm_pkg: shared types and constants for the texture transparency mask
// Holds the map geometry, field widths, item and decode structures, and the
// codes for item kinds, pixel formats, register indexes and sequencer states.
// ============================================================================
package tbm_pkg;

    // Largest image the map is sized for.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    // Map geometry: one bit per pixel, a row padded to whole bytes.
    localparam int BPR_MAX     = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = BPR_MAX * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BPR_W       = $clog2(BPR_MAX + 1);

    // Field widths of the item and configuration words.
    localparam int FUNC_W   = 2;
    localparam int BLK_W    = 8;
    localparam int WORD_W   = 64;
    localparam int COORD_W  = 10;
    localparam int ALPHA_W  = 8;
    localparam int DIM_W    = 11;
    localparam int FMT_W    = 2;
    localparam int CMP_W    = 16;
    localparam int XB_W     = COORD_W - 3;
    localparam int PROD_W   = COORD_W + BPR_W;
    localparam int ROWS_W   = 3;
    localparam int MASKS_W  = 32;

    // Stream and configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int S_FIELDS_W = 2 * BLK_W + 2 * WORD_W + 2 * COORD_W + ALPHA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Reset values of the dimension registers.
    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);

    // Item kinds; code 3 has no meaning and is rejected.
    typedef enum logic [FUNC_W-1:0] {
        FN_BLOCK = 2'd0,
        FN_PIXEL = 2'd1,
        FN_QUERY = 2'd2
    } t_func;

    // Pixel formats.
    typedef enum logic [FMT_W-1:0] {
        FMT_RAW   = 2'd0,
        FMT_DXT1A = 2'd1,
        FMT_DXT3  = 2'd2,
        FMT_DXT1  = 2'd3
    } t_fmt;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_RMW,
        ST_DONE
    } t_state;

    // One captured input word.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BLK_W-1:0]   block_col;
        logic [BLK_W-1:0]   block_row;
        logic [WORD_W-1:0]  color_word;
        logic [WORD_W-1:0]  alpha_word;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ALPHA_W-1:0] pixel_alpha;
    } t_item;

    // What the sequencer needs to know about one item.
    typedef struct packed {
        logic               err;
        logic               query;
        logic [ROWS_W-1:0]  rows;
        logic [MASKS_W-1:0] masks;
        logic [COORD_W-1:0] y;
        logic [XB_W-1:0]    xbyte;
        logic [2:0]         bitsel;
    } t_dec;

    // Requests to the mask memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== sv/tbm_ram.sv =====
// ============================================================================
// tbm_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module tbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tbm_decode.sv =====
// ============================================================================
// tbm_decode: item check and per-row mark masks
// Checks a captured word against the geometry and format, and works out the
// row origin, byte column and the bits to set in each affected map row.
// ============================================================================
module tbm_decode (
    input  tbm_pkg::t_item             i_item,
    input  tbm_pkg::t_fmt              i_fmt,
    input  logic [tbm_pkg::DIM_W-1:0]  i_width,
    input  logic [tbm_pkg::DIM_W-1:0]  i_height,
    output tbm_pkg::t_dec              o_dec
);

    logic                         geom_ok;
    logic                         pix_in;
    logic                         blk_in;
    logic                         c_le;
    logic [tbm_pkg::DIM_W-1:0]    x_end;
    logic [tbm_pkg::DIM_W-1:0]    y_end;
    logic [3:0]                   nib;
    logic [7:0]                   pix_mask;
    logic [tbm_pkg::MASKS_W-1:0]  blk_masks;

    // Geometry registers within the map's bounds.
    assign geom_ok = (i_width != '0) && (i_height != '0) &&
                     (tbm_pkg::CMP_W'(i_width)  <= tbm_pkg::CMP_W'(tbm_pkg::MAX_WIDTH)) &&
                     (tbm_pkg::CMP_W'(i_height) <= tbm_pkg::CMP_W'(tbm_pkg::MAX_HEIGHT));

    // Pixel inside the image.
    assign pix_in = ({1'b0, i_item.pixel_x} < i_width) &&
                    ({1'b0, i_item.pixel_y} < i_height);

    // Whole 4x4 block inside the image.
    assign x_end  = {1'b0, i_item.block_col, 2'b00} + tbm_pkg::DIM_W'(4);
    assign y_end  = {1'b0, i_item.block_row, 2'b00} + tbm_pkg::DIM_W'(4);
    assign blk_in = (x_end <= i_width) && (y_end <= i_height);

    assign c_le = i_item.color_word[15:0] <= i_item.color_word[31:16];

    // Block marks, one nibble per block row, placed in the byte half that
    // the block column selects.
    always_comb begin
        blk_masks = '0;
        nib       = '0;
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) begin
                unique case (i_fmt)
                    tbm_pkg::FMT_DXT1A: nib[i] =
                        (i_item.color_word[32 + 2 * (4 * j + i) +: 2] == 2'h3) && c_le;
                    tbm_pkg::FMT_DXT3:  nib[i] =
                        (i_item.alpha_word[4 * (4 * j + i) +: 4] == 4'h0);
                    tbm_pkg::FMT_RAW,
                    tbm_pkg::FMT_DXT1:  nib[i] = 1'b0;
                endcase
            end
            blk_masks[8 * j +: 8] = i_item.block_col[0] ? {nib, 4'b0000} : {4'b0000, nib};
        end
    end

    // Pixel write marks only a fully transparent pixel.
    assign pix_mask = (i_item.pixel_alpha == '0) ? (8'd1 << i_item.pixel_x[2:0]) : 8'd0;

    // Result per item kind.
    always_comb begin
        o_dec        = '0;
        o_dec.err    = 1'b1;
        o_dec.rows   = tbm_pkg::ROWS_W'(1);
        o_dec.y      = i_item.pixel_y;
        o_dec.xbyte  = i_item.pixel_x[tbm_pkg::COORD_W-1:3];
        o_dec.bitsel = i_item.pixel_x[2:0];
        unique case (i_item.func)
            tbm_pkg::FN_BLOCK: begin
                o_dec.err   = !(geom_ok && blk_in && (i_fmt != tbm_pkg::FMT_RAW));
                o_dec.rows  = tbm_pkg::ROWS_W'(4);
                o_dec.y     = {i_item.block_row, 2'b00};
                o_dec.xbyte = i_item.block_col[tbm_pkg::BLK_W-1:1];
                o_dec.masks = blk_masks;
            end
            tbm_pkg::FN_PIXEL: begin
                o_dec.err   = !(geom_ok && pix_in && (i_fmt == tbm_pkg::FMT_RAW));
                o_dec.masks = {24'd0, pix_mask};
            end
            tbm_pkg::FN_QUERY: begin
                o_dec.err   = !(geom_ok && pix_in);
                o_dec.query = 1'b1;
            end
            default: begin
                o_dec.err   = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/tbm_ctrl.sv =====
// ============================================================================
// tbm_ctrl: mask memory sequencer
// Clears the map after reset, then runs each item as a pipelined
// read-modify-write over its map rows and holds the result in an output
// register until it is taken.
// ============================================================================
module tbm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    input  tbm_pkg::t_dec              i_dec,
    input  logic [tbm_pkg::BPR_W-1:0]  i_bpr,
    output tbm_pkg::t_ram_req          o_ram,
    input  logic [7:0]                 i_ram_rdata,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic                       o_res_bit,
    output logic                       o_res_err
);

    tbm_pkg::t_state                r_state, n_state;
    logic [tbm_pkg::ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic [tbm_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [tbm_pkg::ADDR_W-1:0]     r_waddr, n_waddr;
    logic [tbm_pkg::ROWS_W-1:0]     r_cnt, n_cnt;
    logic [tbm_pkg::ROWS_W-1:0]     r_rows, n_rows;
    logic [tbm_pkg::MASKS_W-1:0]    r_masks, n_masks;
    logic                           r_query, n_query;
    logic                           r_err, n_err;
    logic                           r_bit, n_bit;
    logic [2:0]                     r_bitsel, n_bitsel;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_bit, n_out_bit;
    logic                           r_out_err, n_out_err;
    logic [tbm_pkg::PROD_W-1:0]     row_base;

    // Start address of the first row: row times bytes per row plus column.
    assign row_base = tbm_pkg::PROD_W'(i_dec.y) * tbm_pkg::PROD_W'(i_bpr) +
                      tbm_pkg::PROD_W'(i_dec.xbyte);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbm_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_waddr   <= n_waddr;
        r_cnt     <= n_cnt;
        r_rows    <= n_rows;
        r_masks   <= n_masks;
        r_query   <= n_query;
        r_err     <= n_err;
        r_bit     <= n_bit;
        r_bitsel  <= n_bitsel;
        r_out_bit <= n_out_bit;
        r_out_err <= n_out_err;
    end

    // Sequencer: next state, memory requests and result loading.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_addr       = r_addr;
        n_waddr      = r_waddr;
        n_cnt        = r_cnt;
        n_rows       = r_rows;
        n_masks      = r_masks;
        n_query      = r_query;
        n_err        = r_err;
        n_bit        = r_bit;
        n_bitsel     = r_bitsel;
        n_out_bit    = r_out_bit;
        n_out_err    = r_out_err;
        n_out_valid  = r_out_valid && !i_res_ready;
        o_item_ready = 1'b0;
        o_ram        = '0;

        unique case (r_state)
            tbm_pkg::ST_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr_addr;
                o_ram.wdata = 8'd0;
                n_clr_addr  = r_clr_addr + tbm_pkg::ADDR_W'(1);
                if (r_clr_addr == tbm_pkg::ADDR_W'(tbm_pkg::STORE_DEPTH - 1)) begin
                    n_state = tbm_pkg::ST_IDLE;
                end
            end
            tbm_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_state = tbm_pkg::ST_CALC;
                end
            end
            tbm_pkg::ST_CALC: begin
                n_addr   = tbm_pkg::ADDR_W'(row_base);
                n_rows   = i_dec.rows;
                n_masks  = i_dec.masks;
                n_query  = i_dec.query;
                n_err    = i_dec.err;
                n_bitsel = i_dec.bitsel;
                n_bit    = 1'b0;
                n_cnt    = '0;
                n_state  = i_dec.err ? tbm_pkg::ST_DONE : tbm_pkg::ST_RMW;
            end
            tbm_pkg::ST_RMW: begin
                // Read the next row while the previous one is written back.
                if (r_cnt < r_rows) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_addr;
                    n_addr      = r_addr + tbm_pkg::ADDR_W'(i_bpr);
                    n_waddr     = r_addr;
                end
                if (r_cnt != '0) begin
                    if (r_query) begin
                        n_bit = i_ram_rdata[r_bitsel];
                    end else begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_waddr;
                        o_ram.wdata = i_ram_rdata | r_masks[7:0];
                        n_masks     = r_masks >> 8;
                    end
                end
                n_cnt = r_cnt + tbm_pkg::ROWS_W'(1);
                if (r_cnt == r_rows) begin
                    n_state = tbm_pkg::ST_DONE;
                end
            end
            tbm_pkg::ST_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_bit && !r_err;
                    n_out_err   = r_err;
                    n_state     = tbm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_out_valid;
    assign o_res_bit   = r_out_bit;
    assign o_res_err   = r_out_err;

    // A write-back never lands on the row being read in the same cycle.
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram.we && o_ram.re) |-> (o_ram.waddr != o_ram.raddr))
        else $error("mask memory read and write hit the same byte");

    // The clearing pass writes zeros and holds off input.
    a_clear_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbm_pkg::ST_CLEAR) |-> (o_ram.we && (o_ram.wdata == 8'd0) && !o_item_ready))
        else $error("clearing pass misbehaves");

    // A query only reads the map.
    a_query_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tbm_pkg::ST_RMW) && r_query) |-> !o_ram.we)
        else $error("query wrote the mask memory");

    // The row counter never passes the row count of the item.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbm_pkg::ST_RMW) |-> (r_cnt <= r_rows))
        else $error("row counter overran");

endmodule

// ===== sv/texture_block_transparency_mask.sv =====
// ============================================================================
// texture_block_transparency_mask: one-bit-per-pixel transparency map
// Top level: configuration registers, input capture, decode, sequencer and
// the byte-wide mask memory.
// ============================================================================
// Usage:
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   while the block is idle: pixel format, image width, image height.
//   Each input word on s_axis carries a block write, a pixel alpha write or a
//   point query (kind in s_axis_tuser); each gives exactly one result word on
//   m_axis holding the transparent bit and an error status.
//   An accepted word is decoded; a block write then runs the read-modify-write
//   over its four map rows, a pixel write or query over one row, and a rejected
//   word skips it before its result is loaded. Words are taken one at a time
//   and the next one is accepted the cycle after its predecessor's result is
//   loaded. The read-modify-write sequence over the mask memory reads one row
//   per cycle on its read port, with the write-back of each row of a write
//   following in the cycle after on the write port.
//   After reset the map is cleared by a pass over all 131072 bytes, one byte per
//   cycle, during which s_axis_tready stays low; configuration writes are
//   still taken. A result waits in an output register while m_axis_tready is
//   low; the next word is accepted meanwhile and its result is held back
//   until the register frees up.
// ============================================================================
module texture_block_transparency_mask (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_wr_en,
    input  logic [tbm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input words.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // block_col[7:0], block_row[15:8], color_word[79:16], alpha_word[143:80],
    // pixel_x[153:144], pixel_y[163:154], pixel_alpha[171:164], zero fill
    input  logic [tbm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [tbm_pkg::FUNC_W-1:0]       s_axis_tuser,
    // Result words.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // transparent[0], status[1], zero fill
    output logic [tbm_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    tbm_pkg::t_fmt                  r_pixel_format;
    logic [tbm_pkg::DIM_W-1:0]      r_image_width;
    logic [tbm_pkg::DIM_W-1:0]      r_image_height;
    tbm_pkg::t_item                 r_item;
    tbm_pkg::t_dec                  dec;
    tbm_pkg::t_ram_req              ram_req;
    logic [7:0]                     ram_rdata;
    logic [tbm_pkg::DIM_W:0]        width_pad;
    logic [tbm_pkg::BPR_W-1:0]      bpr;
    logic                           item_ready;
    logic                           res_bit;
    logic                           res_err;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= tbm_pkg::FMT_RAW;
            r_image_width  <= tbm_pkg::WIDTH_RST;
            r_image_height <= tbm_pkg::HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tbm_pkg::CFG_FORMAT: r_pixel_format <= tbm_pkg::t_fmt'(i_cfg_wdata[1:0]);
                tbm_pkg::CFG_WIDTH:  r_image_width  <= i_cfg_wdata;
                tbm_pkg::CFG_HEIGHT: r_image_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Map bytes per row.
    assign width_pad = {1'b0, r_image_width} + (tbm_pkg::DIM_W + 1)'(7);
    assign bpr       = width_pad[tbm_pkg::BPR_W+2:3];

    // Capture the accepted input word.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && item_ready) begin
            r_item.func        <= s_axis_tuser;
            r_item.block_col   <= s_axis_tdata[7:0];
            r_item.block_row   <= s_axis_tdata[15:8];
            r_item.color_word  <= s_axis_tdata[79:16];
            r_item.alpha_word  <= s_axis_tdata[143:80];
            r_item.pixel_x     <= s_axis_tdata[153:144];
            r_item.pixel_y     <= s_axis_tdata[163:154];
            r_item.pixel_alpha <= s_axis_tdata[171:164];
        end
    end

    tbm_decode u_decode (
        .i_item   (r_item),
        .i_fmt    (r_pixel_format),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .o_dec    (dec)
    );

    tbm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (item_ready),
        .i_dec        (dec),
        .i_bpr        (bpr),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_bit    (res_bit),
        .o_res_err    (res_err)
    );

    tbm_ram #(
        .WIDTH (8),
        .DEPTH (tbm_pkg::STORE_DEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = item_ready;
    assign m_axis_tdata  = {(tbm_pkg::M_TDATA_W - 2)'(0), res_err, res_bit};

endmodule

// ===== dv/tbm_mask_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tbm_mask_checker: result checker for the texture transparency mask
// Watches the configuration port and both stream channels. Every accepted
// input word is run through a shadow copy of the transparency map to work
// out the result word it must produce; every accepted result word is
// compared field by field with the oldest one still awaited.
// ============================================================================
module tbm_mask_checker
    import tbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Bit offsets of the fields inside the input tdata.
    localparam int BCOL_LO  = 0;
    localparam int BROW_LO  = BCOL_LO + BLK_W;
    localparam int CWORD_LO = BROW_LO + BLK_W;
    localparam int AWORD_LO = CWORD_LO + WORD_W;
    localparam int PX_LO    = AWORD_LO + WORD_W;
    localparam int PY_LO    = PX_LO + COORD_W;
    localparam int PA_LO    = PY_LO + COORD_W;

    typedef struct packed {
        logic transparent;
        logic status;
    } t_reply;

    // Shadow state: map bytes and the three registers.
    bit [7:0] shadow_map [STORE_DEPTH];
    t_fmt     fmt_r;
    int       width_r;
    int       height_r;
    t_reply   reply_queue [$];
    int       fail_total;
    int       replies_seen;

    // Byte of the map that holds pixel (x, y) under the current row layout.
    function automatic int map_offset(input int x, input int y);
        return y * ((width_r + 7) / 8) + x / 8;
    endfunction

    function automatic void mark_texel(input int x, input int y);
        int offset;
        offset = map_offset(x, y);
        if (offset < STORE_DEPTH) begin
            shadow_map[offset][x % 8] = 1'b1;
        end
    endfunction

    // Applies one input word to the shadow map and returns its result word.
    function automatic t_reply apply_word(input logic [FUNC_W-1:0] kind,
                                          input logic [S_TDATA_W-1:0] data);
        t_reply             reply;
        int                 bcol;
        int                 brow;
        int                 px;
        int                 py;
        int                 x0;
        int                 y0;
        int                 offset;
        int                 texel;
        logic [15:0]        color0;
        logic [15:0]        color1;
        logic [WORD_W-1:0]  cword;
        logic [WORD_W-1:0]  aword;
        logic [ALPHA_W-1:0] alpha;
        bit                 hit;
        bcol   = int'(data[BCOL_LO +: BLK_W]);
        brow   = int'(data[BROW_LO +: BLK_W]);
        cword  = data[CWORD_LO +: WORD_W];
        aword  = data[AWORD_LO +: WORD_W];
        px     = int'(data[PX_LO +: COORD_W]);
        py     = int'(data[PY_LO +: COORD_W]);
        alpha  = data[PA_LO +: ALPHA_W];
        color0 = cword[15:0];
        color1 = cword[31:16];
        reply.transparent = 1'b0;
        reply.status      = 1'b1;
        if (width_r >= 1 && width_r <= MAX_WIDTH && height_r >= 1 &&
            height_r <= MAX_HEIGHT) begin
            if (kind == FN_BLOCK) begin
                x0 = bcol * 4;
                y0 = brow * 4;
                // Whole 4x4 block inside the image, compressed format only.
                if (fmt_r != FMT_RAW && x0 + 4 <= width_r && y0 + 4 <= height_r) begin
                    reply.status = 1'b0;
                    for (texel = 0; texel < 16; texel++) begin
                        case (fmt_r)
                            FMT_DXT1A: begin
                                hit = (cword[32 + 2 * texel +: 2] == 2'b11) &&
                                      (color0 <= color1);
                            end
                            FMT_DXT3: begin
                                hit = (aword[4 * texel +: 4] == 4'h0);
                            end
                            default: begin
                                hit = 1'b0;
                            end
                        endcase
                        if (hit) begin
                            mark_texel(x0 + texel % 4, y0 + texel / 4);
                        end
                    end
                end
            end else if (kind == FN_PIXEL) begin
                if (fmt_r == FMT_RAW && px < width_r && py < height_r) begin
                    reply.status = 1'b0;
                    if (alpha == '0) begin
                        mark_texel(px, py);
                    end
                end
            end else if (kind == FN_QUERY) begin
                if (px < width_r && py < height_r) begin
                    reply.status = 1'b0;
                    offset = map_offset(px, py);
                    if (offset < STORE_DEPTH) begin
                        reply.transparent = shadow_map[offset][px % 8];
                    end
                end
            end
        end
        return reply;
    endfunction

    // Track registers, predict on input words, compare on result words.
    always @(posedge i_clk) begin : watch
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            foreach (shadow_map[i]) begin
                shadow_map[i] = 8'h00;
            end
            fmt_r        = FMT_RAW;
            width_r      = int'(WIDTH_RST);
            height_r     = int'(HEIGHT_RST);
            fail_total   = 0;
            replies_seen = 0;
            reply_queue.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.transparent = m_axis_tdata[0];
                got.status      = m_axis_tdata[1];
                if (reply_queue.size() == 0) begin
                    if (fail_total < 10) begin
                        $display("checker: result word %0d arrived with none awaited: %b",
                                 replies_seen, m_axis_tdata);
                    end
                    fail_total++;
                end else begin
                    want = reply_queue.pop_front();
                    if (got.transparent !== want.transparent ||
                        got.status !== want.status) begin
                        if (fail_total < 10) begin
                            $display({"checker: result word %0d: expected transparent=%0b ",
                                      "status=%0b, got transparent=%0b status=%0b"},
                                     replies_seen, want.transparent, want.status,
                                     got.transparent, got.status);
                        end
                        fail_total++;
                    end
                end
                replies_seen++;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FORMAT: fmt_r    = t_fmt'(i_cfg_wdata[FMT_W-1:0]);
                    CFG_WIDTH:  width_r  = int'(i_cfg_wdata);
                    CFG_HEIGHT: height_r = int'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // Append the predicted result at the tail of the queue.
                reply_queue = {reply_queue, apply_word(s_axis_tuser, s_axis_tdata)};
            end
        end
        o_fail_count = fail_total;
        o_pending    = reply_queue.size();
    end

endmodule

// ===== dv/tb_texture_block_transparency_mask.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_texture_block_transparency_mask: testbench top for the transparency mask
// Drives a directed opening (reset defaults, every word kind, edge blocks,
// bad geometry) and then phases of random words under many register
// settings, with random gaps on the input and random stalls on the output.
// The checker beside the block predicts and compares every result word.
// ============================================================================
module tb_texture_block_transparency_mask;
    import tbm_pkg::*;

    // Kind code with no meaning; the block must reject it.
    localparam logic [FUNC_W-1:0] FN_UNDEFINED = 2'd3;
    // Longest stretch without any accepted word or taken result; it must outlast
    // the clearing pass over all 131072 map bytes after reset.
    localparam int IDLE_LIMIT = 400000;
    localparam int PHASES     = 14;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int   words_sent;
    int   results_taken;
    int   idle_cycles;
    int   fail_count;
    int   pending_count;
    bit   steady;
    t_fmt cur_fmt;
    int   cur_w;
    int   cur_h;
    int   hot_x;
    int   hot_y;

    texture_block_transparency_mask DUT (.*);

    tbm_mask_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Word counters and the idle counter for the watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_sent    <= 0;
            results_taken <= 0;
            idle_cycles   <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                words_sent <= words_sent + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_taken <= results_taken + 1;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: a random stall before each word, none in steady stretches.
    initial begin : result_sink
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Offers one input word after a random gap and waits for its handshake.
    // The valid stays high afterwards so that a gapless next word follows.
    task automatic send_word(input logic [FUNC_W-1:0]  kind,
                             input logic [BLK_W-1:0]   bcol,
                             input logic [BLK_W-1:0]   brow,
                             input logic [WORD_W-1:0]  cword,
                             input logic [WORD_W-1:0]  aword,
                             input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py,
                             input logic [ALPHA_W-1:0] alpha);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= S_TDATA_W'({alpha, py, px, aword, cword, brow, bcol});
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Holds the input side until every awaited result word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_taken != words_sent);
    endtask

    // Writes all three registers while the block is idle.
    task automatic set_config(input t_fmt fmt, input int w, input int h);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FORMAT;
        i_cfg_wdata <= CFG_DATA_W'(fmt);
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_wdata <= CFG_DATA_W'(h);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_fmt = fmt;
        cur_w   = w;
        cur_h   = h;
    endtask

    // One random word, mostly well-formed for the current setting.
    task automatic send_random_word();
        int                 pick;
        int                 roll;
        int                 xlim;
        int                 ylim;
        int                 nib;
        logic [FUNC_W-1:0]  kind;
        logic [BLK_W-1:0]   bcol;
        logic [BLK_W-1:0]   brow;
        logic [15:0]        color0;
        logic [15:0]        color1;
        logic [15:0]        swap;
        logic [31:0]        indices;
        logic [WORD_W-1:0]  aword;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [ALPHA_W-1:0] alpha;
        xlim = (cur_w >= 1 && cur_w <= MAX_WIDTH) ? cur_w - 1 : MAX_WIDTH - 1;
        ylim = (cur_h >= 1 && cur_h <= MAX_HEIGHT) ? cur_h - 1 : MAX_HEIGHT - 1;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            kind = FN_UNDEFINED;
        end else if (pick < 50) begin
            kind = (cur_fmt == FMT_RAW) ? FN_PIXEL : FN_BLOCK;
        end else if (pick < 58) begin
            kind = (cur_fmt == FMT_RAW) ? FN_BLOCK : FN_PIXEL;
        end else begin
            kind = FN_QUERY;
        end

        // Block position: inside the image most of the time.
        if ($urandom_range(0, 99) < 85 && cur_w >= 4 && cur_w <= MAX_WIDTH &&
            cur_h >= 4 && cur_h <= MAX_HEIGHT) begin
            bcol = BLK_W'($urandom_range(0, cur_w / 4 - 1));
            brow = BLK_W'($urandom_range(0, cur_h / 4 - 1));
        end else begin
            bcol = BLK_W'($urandom);
            brow = BLK_W'($urandom);
        end

        // Colors mostly ordered for punch-through, indices leaning toward 3.
        color0 = 16'($urandom);
        color1 = 16'($urandom);
        roll   = $urandom_range(0, 9);
        if (roll < 6 && color0 > color1) begin
            swap   = color0;
            color0 = color1;
            color1 = swap;
        end else if (roll == 6) begin
            color1 = color0;
        end
        indices = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | $urandom);

        // Explicit alphas with many zero nibbles.
        for (nib = 0; nib < 16; nib++) begin
            aword[4 * nib +: 4] = ($urandom_range(0, 9) < 4) ? 4'h0 : 4'($urandom);
        end

        // Pixel position: near the last write for half the queries.
        if (kind == FN_QUERY && $urandom_range(0, 1) == 0) begin
            px = COORD_W'(hot_x + $urandom_range(0, 3));
            py = COORD_W'(hot_y + $urandom_range(0, 3));
        end else if ($urandom_range(0, 99) < 85) begin
            px = COORD_W'($urandom_range(0, xlim));
            py = COORD_W'($urandom_range(0, ylim));
        end else begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end
        alpha = ($urandom_range(0, 1) == 0) ? '0 : ALPHA_W'($urandom);

        if (kind == FN_BLOCK) begin
            hot_x = int'(bcol) * 4;
            hot_y = int'(brow) * 4;
        end else if (kind == FN_PIXEL) begin
            hot_x = int'(px);
            hot_y = int'(py);
        end
        send_word(kind, bcol, brow, {indices, color1, color0}, aword, px, py, alpha);
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int   phase;
        int   count;
        int   words;
        int   w;
        int   h;
        t_fmt fmt;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_FORMAT;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FN_BLOCK;
        steady  = 1'b0;
        cur_fmt = FMT_RAW;
        cur_w   = int'(WIDTH_RST);
        cur_h   = int'(HEIGHT_RST);
        hot_x   = 0;
        hot_y   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: uncompressed 1024 x 1024, corners and opaque pixels.
        send_word(FN_PIXEL, '0, '0, '0, '0, '0, '0, '0);
        send_word(FN_PIXEL, '0, '0, '0, '0, '1, '1, '0);
        send_word(FN_PIXEL, '0, '0, '0, '0, 10'd5, 10'd3, '1);
        send_word(FN_QUERY, '0, '0, '0, '0, '0, '0, '0);
        send_word(FN_QUERY, '0, '0, '1, '1, '1, '1, '1);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd5, 10'd3, '0);
        // A block in uncompressed mode and an unknown kind are rejected.
        send_word(FN_BLOCK, '0, '0, '1, '0, '0, '0, '0);
        send_word(FN_UNDEFINED, '0, '0, '0, '0, '0, '0, '0);

        // Punch-through on a 16 x 12 image: full block, opaque colors, edges.
        set_config(FMT_DXT1A, 16, 12);
        send_word(FN_BLOCK, '0, '0, {32'hFFFF_FFFF, 16'hFFFF, 16'h0000}, '0, '0, '0, '0);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd3, 10'd3, '0);
        send_word(FN_BLOCK, 8'd3, 8'd2, {32'hFFFF_FFFF, 16'h0000, 16'hFFFF}, '0, '0, '0, '0);
        send_word(FN_BLOCK, 8'd4, '0, '1, '0, '0, '0, '0);
        send_word(FN_BLOCK, '0, 8'd3, '1, '0, '0, '0, '0);
        send_word(FN_BLOCK, '1, '1, '1, '0, '0, '0, '0);
        // Pixel write in a compressed mode, query just outside and at corner.
        send_word(FN_PIXEL, '0, '0, '0, '0, 10'd1, 10'd1, '0);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd16, '0, '0);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd15, 10'd11, '0);

        // Explicit alpha: last block of the largest image, then all opaque.
        set_config(FMT_DXT3, 1024, 1024);
        send_word(FN_BLOCK, '1, '1, '0, '0, '0, '0, '0);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd1020, 10'd1022, '0);
        send_word(FN_BLOCK, 8'd1, 8'd1, '0, '1, '0, '0, '0);

        // Color-only format accepts blocks but marks nothing.
        set_config(FMT_DXT1, 1024, 1024);
        send_word(FN_BLOCK, 8'd1, 8'd1, {32'hFFFF_FFFF, 32'h0000_FFFF}, '0, '0, '0, '0);
        send_word(FN_QUERY, '0, '0, '0, '0, 10'd4, 10'd4, '0);

        // A zero width rejects everything.
        set_config(FMT_RAW, 0, 1024);
        send_word(FN_QUERY, '0, '0, '0, '0, '0, '0, '0);

        // Random phases over many settings, extremes among them.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:  begin fmt = FMT_RAW;   w = 1024;  h = 1024; words = 100; end
                1:  begin fmt = FMT_DXT1A; w = 16;    h = 16;   words = 100; end
                2:  begin fmt = FMT_DXT3;  w = 13;    h = 9;    words = 100; end
                3:  begin fmt = FMT_RAW;   w = 8;     h = 8;    words = 100; end
                4:  begin fmt = FMT_DXT1;  w = 32;    h = 32;   words = 60;  end
                5:  begin fmt = FMT_DXT1A; w = 1024;  h = 1024; words = 100; end
                6:  begin fmt = FMT_RAW;   w = 1;     h = 1;    words = 40;  end
                7:  begin fmt = FMT_DXT3;  w = 64;    h = 40;   words = 100; end
                8:  begin fmt = FMT_DXT1A; w = 4;     h = 4;    words = 60;  end
                9:  begin fmt = FMT_RAW;   w = 24;    h = 0;    words = 20;  end
                10: begin fmt = FMT_DXT3;  w = 1025;  h = 2047; words = 20;  end
                11: begin fmt = FMT_RAW;   w = 37;    h = 1024; words = 100; end
                12: begin fmt = FMT_DXT3;  w = 1024;  h = 4;    words = 100; end
                default: begin
                    fmt   = FMT_DXT1A;
                    w     = $urandom_range(4, 64);
                    h     = $urandom_range(4, 64);
                    words = 100;
                end
            endcase
            set_config(fmt, w, h);
            steady = (phase % 4 == 1);
            for (count = 0; count < words; count++) begin
                // Now and then let the block run dry before going on.
                if ($urandom_range(0, 49) == 0) begin
                    drain_results();
                end
                send_random_word();
            end
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tbm_pkg.sv
sv/tbm_ram.sv
sv/tbm_decode.sv
sv/tbm_ctrl.sv
sv/texture_block_transparency_mask.sv
dv/tbm_mask_checker.sv
dv/tb_texture_block_transparency_mask.sv
